### rtl/tdts_pkg.sv
// Shared types for the token scanner: token beat and token pair records.
// No dependencies; used by the front, queue and back modules.
`default_nettype none

package tdts_pkg;

	localparam int CODE_W = 5;
	localparam int KIND_W = 2;

	// one token as it leaves the block
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [KIND_W-1:0] kind;
	} tdts_tok_t;

	// tokens caused by one input beat: tok0 always valid, tok1 only when two
	typedef struct packed {
		logic      two;
		tdts_tok_t tok0;
		tdts_tok_t tok1;
	} tdts_pair_t;

endpackage

`default_nettype wire

### rtl/tdts_front.sv
// Scanner front: classifies each byte and steps the scanner automaton.
// Produces the token pair for each input beat. Depends on tdts_pkg.
`default_nettype none

module tdts_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 take,
	input  wire  [7:0]          char_code,
	input  wire                 end_of_text,
	output logic                push,
	output tdts_pkg::tdts_pair_t pair
);
	import tdts_pkg::*;

	// character classes
	localparam logic [3:0] CL_LET   = 4'd0;
	localparam logic [3:0] CL_DIG   = 4'd1;
	localparam logic [3:0] CL_PLUS  = 4'd2;
	localparam logic [3:0] CL_MINUS = 4'd3;
	localparam logic [3:0] CL_STAR  = 4'd4;
	localparam logic [3:0] CL_SLASH = 4'd5;
	localparam logic [3:0] CL_PCT   = 4'd6;
	localparam logic [3:0] CL_LPAR  = 4'd7;
	localparam logic [3:0] CL_RPAR  = 4'd8;
	localparam logic [3:0] CL_COMMA = 4'd9;
	localparam logic [3:0] CL_SEMI  = 4'd10;
	localparam logic [3:0] CL_COLON = 4'd11;
	localparam logic [3:0] CL_EQ    = 4'd12;
	localparam logic [3:0] CL_END   = 4'd13;
	localparam logic [3:0] CL_SPACE = 4'd14;
	localparam logic [3:0] CL_OTHER = 4'd15;

	// token codes
	localparam logic [CODE_W-1:0] TK_IDENT      = 5'd0;
	localparam logic [CODE_W-1:0] TK_CONST      = 5'd1;
	localparam logic [CODE_W-1:0] TK_PLUS       = 5'd2;
	localparam logic [CODE_W-1:0] TK_MINUS      = 5'd3;
	localparam logic [CODE_W-1:0] TK_OPER       = 5'd4;
	localparam logic [CODE_W-1:0] TK_LPAR       = 5'd5;
	localparam logic [CODE_W-1:0] TK_RPAR       = 5'd6;
	localparam logic [CODE_W-1:0] TK_COMMA      = 5'd7;
	localparam logic [CODE_W-1:0] TK_SEMI       = 5'd8;
	localparam logic [CODE_W-1:0] TK_ASSIGN     = 5'd9;
	localparam logic [CODE_W-1:0] TK_END        = 5'd10;
	localparam logic [CODE_W-1:0] TK_KW0        = 5'd11;
	localparam logic [CODE_W-1:0] TK_ASSIGN_ERR = 5'd16;
	localparam logic [CODE_W-1:0] TK_ERR        = 5'd17;

	localparam logic [KIND_W-1:0] OP_STAR  = 2'd0;
	localparam logic [KIND_W-1:0] OP_SLASH = 2'd1;
	localparam logic [KIND_W-1:0] OP_PCT   = 2'd2;

	// scan states
	localparam logic [4:0] ST_START = 5'd0;
	localparam logic [4:0] ST_IDENT = 5'd1;
	localparam logic [4:0] ST_CONST = 5'd3;
	localparam logic [4:0] ST_COLON = 5'd14;

	localparam int NKW = 5;

	function automatic logic [3:0] classify(input logic [7:0] b);
		logic [3:0] c;
		if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
			c = CL_LET;
		end else if (b >= 8'h30 && b <= 8'h39) begin
			c = CL_DIG;
		end else begin
			case (b)
				8'h2B: c = CL_PLUS;
				8'h2D: c = CL_MINUS;
				8'h2A: c = CL_STAR;
				8'h2F: c = CL_SLASH;
				8'h25: c = CL_PCT;
				8'h28: c = CL_LPAR;
				8'h29: c = CL_RPAR;
				8'h2C: c = CL_COMMA;
				8'h3B: c = CL_SEMI;
				8'h3A: c = CL_COLON;
				8'h3D: c = CL_EQ;
				8'h20, 8'h0D, 8'h0A, 8'h09: c = CL_SPACE;
				default: c = CL_OTHER;
			endcase
		end
		return c;
	endfunction

	function automatic logic [3:0] kw_len(input int k);
		logic [3:0] n;
		case (k)
			0: n = 4'd8;
			1: n = 4'd3;
			2: n = 4'd6;
			3: n = 4'd4;
			4: n = 4'd8;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// keyword spelling: programa, fin, entero, leer, escribir
	function automatic logic [7:0] kw_char(input int k, input logic [2:0] i);
		logic [63:0] w;
		case (k)
			0: w = "amargorp";
			1: w = {40'd0, "nif"};
			2: w = {16'd0, "oretne"};
			3: w = {32'd0, "reel"};
			4: w = "ribircse";
			default: w = 64'd0;
		endcase
		return w[{i, 3'b000} +: 8];
	endfunction

	// drop keywords whose next letter does not match
	function automatic logic [NKW-1:0] kw_step(input logic [NKW-1:0] hits,
			input logic [3:0] len, input logic [7:0] b);
		logic [NKW-1:0] h;
		for (int k = 0; k < NKW; k++) begin
			h[k] = hits[k] && (len < kw_len(k)) && (kw_char(k, len[2:0]) == b);
		end
		return h;
	endfunction

	logic [4:0]     scan_state_q;
	logic [NKW-1:0] keyword_hits_q;
	logic [3:0]     lexeme_length_q;
	logic           bad_char_seen_q;

	logic [4:0]     st_d;
	logic [NKW-1:0] hits_d;
	logic [3:0]     len_d;
	logic           bad_d;

	logic [3:0]     cl;
	logic [3:0]     len_inc;
	logic           lead_vld, sp_vld;
	tdts_tok_t      lead_tok, sp_tok, id_tok;
	logic           do_start, do_collect, coll_bad;

	assign cl      = end_of_text ? CL_END : classify(char_code);
	assign len_inc = (lexeme_length_q == 4'hF) ? lexeme_length_q : lexeme_length_q + 4'd1;

	// identifier end token
	always_comb begin
		id_tok.kind = OP_STAR;
		id_tok.code = TK_IDENT;
		if (bad_char_seen_q) begin
			id_tok.code = TK_ERR;
		end else begin
			for (int k = NKW - 1; k >= 0; k--) begin
				if (keyword_hits_q[k] && lexeme_length_q == kw_len(k)) begin
					id_tok.code = TK_KW0 + CODE_W'(k);
				end
			end
		end
	end

	// token from the start state
	always_comb begin
		sp_vld      = 1'b1;
		sp_tok.kind = OP_STAR;
		sp_tok.code = TK_ERR;
		case (cl)
			CL_SPACE, CL_LET, CL_DIG, CL_COLON: sp_vld = 1'b0;
			CL_EQ:    sp_tok.code = TK_ASSIGN_ERR;
			CL_END:   sp_tok.code = TK_END;
			CL_PLUS:  sp_tok.code = TK_PLUS;
			CL_MINUS: sp_tok.code = TK_MINUS;
			CL_STAR:  sp_tok.code = TK_OPER;
			CL_SLASH: begin
				sp_tok.code = TK_OPER;
				sp_tok.kind = OP_SLASH;
			end
			CL_PCT: begin
				sp_tok.code = TK_OPER;
				sp_tok.kind = OP_PCT;
			end
			CL_LPAR:  sp_tok.code = TK_LPAR;
			CL_RPAR:  sp_tok.code = TK_RPAR;
			CL_COMMA: sp_tok.code = TK_COMMA;
			CL_SEMI:  sp_tok.code = TK_SEMI;
			default:  sp_tok.code = TK_ERR;
		endcase
	end

	// automaton step
	always_comb begin
		lead_vld      = 1'b0;
		lead_tok.code = TK_IDENT;
		lead_tok.kind = OP_STAR;
		do_start      = 1'b0;
		do_collect    = 1'b0;
		coll_bad      = 1'b0;
		case (scan_state_q)
			ST_IDENT: begin
				if (cl == CL_LET || cl == CL_DIG || cl == CL_OTHER) begin
					do_collect = 1'b1;
					coll_bad   = (cl == CL_OTHER);
				end else begin
					lead_vld = 1'b1;
					lead_tok = id_tok;
					do_start = 1'b1;
				end
			end
			ST_CONST: begin
				if (cl == CL_LET || cl == CL_DIG) begin
					do_collect = 1'b1;
					coll_bad   = (cl == CL_LET);
				end else begin
					lead_vld      = 1'b1;
					lead_tok.code = bad_char_seen_q ? TK_ERR : TK_CONST;
					do_start      = 1'b1;
				end
			end
			ST_COLON: begin
				lead_vld      = 1'b1;
				lead_tok.code = (cl == CL_EQ) ? TK_ASSIGN : TK_ASSIGN_ERR;
			end
			default: do_start = 1'b1;
		endcase

		// next lexeme state
		st_d   = ST_START;
		hits_d = '1;
		len_d  = 4'd0;
		bad_d  = 1'b0;
		if (do_collect) begin
			st_d   = scan_state_q;
			hits_d = kw_step(keyword_hits_q, lexeme_length_q, char_code);
			len_d  = len_inc;
			bad_d  = bad_char_seen_q | coll_bad;
		end else if (do_start) begin
			case (cl)
				CL_LET, CL_DIG: begin
					st_d   = (cl == CL_LET) ? ST_IDENT : ST_CONST;
					hits_d = kw_step('1, 4'd0, char_code);
					len_d  = 4'd1;
				end
				CL_COLON: st_d = ST_COLON;
				default:  st_d = ST_START;
			endcase
		end
	end

	// pack the pair: the lead token goes first
	always_comb begin
		pair.tok0 = lead_vld ? lead_tok : sp_tok;
		pair.tok1 = sp_tok;
		pair.two  = lead_vld && do_start && sp_vld;
		push      = take && (lead_vld || (do_start && sp_vld));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_state_q    <= ST_START;
			keyword_hits_q  <= '1;
			lexeme_length_q <= 4'd0;
			bad_char_seen_q <= 1'b0;
		end else if (take) begin
			scan_state_q    <= st_d;
			keyword_hits_q  <= hits_d;
			lexeme_length_q <= len_d;
			bad_char_seen_q <= bad_d;
		end
	end

endmodule

`default_nettype wire

### rtl/tdts_queue.sv
// Four-entry queue of token pairs between the scanner front and the output side.
// Show-ahead read of the head entry. Depends on tdts_pkg.
`default_nettype none

module tdts_queue (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       push,
	input  wire tdts_pkg::tdts_pair_t wr_pair,
	output logic                      full,
	input  wire                       pop,
	output logic                      nonempty,
	output tdts_pkg::tdts_pair_t      rd_pair
);
	import tdts_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	tdts_pair_t     mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [AW:0]    count_q;
	logic           do_push, do_pop;

	assign full     = (count_q == (AW+1)'(DEPTH));
	assign nonempty = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign rd_pair  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_pair;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/tdts_back.sv
// Output side: holds one token pair and sends its tokens one beat at a time.
// Marks the final token of each pair as last. Depends on tdts_pkg.
`default_nettype none

module tdts_back (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       q_nonempty,
	input  wire tdts_pkg::tdts_pair_t q_pair,
	output logic                      q_pop,
	output logic                      out_valid,
	input  wire                       out_ready,
	output tdts_pkg::tdts_tok_t       out_tok,
	output logic                      out_last
);
	import tdts_pkg::*;

	tdts_pair_t cur_q;
	logic       cur_vld_q;
	logic       sec_q;
	logic       fire, done, load;

	assign out_valid = cur_vld_q;
	assign out_tok   = sec_q ? cur_q.tok1 : cur_q.tok0;
	assign out_last  = !cur_q.two || sec_q;
	assign fire      = cur_vld_q && out_ready;
	assign done      = fire && out_last;
	assign load      = !cur_vld_q || done;
	assign q_pop     = load && q_nonempty;

	// payload register
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_pair;
		end
	end

	// beat control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			sec_q     <= 1'b0;
		end else if (load) begin
			cur_vld_q <= q_nonempty;
			sec_q     <= 1'b0;
		end else if (fire) begin
			sec_q <= 1'b1;
		end
	end

endmodule

`default_nettype wire

### rtl/table_driven_token_scanner.sv
// Top level of the token scanner: front, pair queue and output side.
// Depends on tdts_pkg, tdts_front, tdts_queue and tdts_back.
//
//  channel | dir | tdata            | tuser              | tlast
//  s_axis  | in  | [7:0] char_code  | [0] end_of_text    | -
//  m_axis  | out | [4:0] token_code | [1:0] operator_kind| last_of_run
//
// One input beat per cycle unless the queue is full; the front steps the scanner.
// Output sends one token per cycle while m_axis_tready is high, so a beat giving
// two tokens gives two output beats; the four-entry queue absorbs such bursts.
// A token reaches m_axis through the queue storage and then the output register.
// s_axis_tready drops while the queue holds four pairs, so m_axis stalls back up.
// Reset clears the scan state, the queue and the output register at once.
`default_nettype none

module table_driven_token_scanner (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire  [7:0] s_axis_tdata,   // [7:0] char_code
	input  wire  [0:0] s_axis_tuser,   // [0] end_of_text
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [4:0] token_code, [7:5] zero
	output logic [1:0] m_axis_tuser,   // [1:0] operator_kind
	output logic       m_axis_tlast    // last_of_run
);
	import tdts_pkg::*;

	logic       take, push, full, pop, nonempty, last;
	tdts_pair_t wr_pair, rd_pair;
	tdts_tok_t  tok;

	assign s_axis_tready = !full;
	assign take          = s_axis_tvalid && !full;

	tdts_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.char_code   (s_axis_tdata),
		.end_of_text (s_axis_tuser[0]),
		.push        (push),
		.pair        (wr_pair)
	);

	tdts_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_pair  (wr_pair),
		.full     (full),
		.pop      (pop),
		.nonempty (nonempty),
		.rd_pair  (rd_pair)
	);

	tdts_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (nonempty),
		.q_pair     (rd_pair),
		.q_pop      (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_tok    (tok),
		.out_last   (last)
	);

	assign m_axis_tdata = {3'b000, tok.code};
	assign m_axis_tuser = tok.kind;
	assign m_axis_tlast = last;

endmodule

`default_nettype wire
